>>> rtl/hpq_pkg.sv
// hpq_pkg: shared types and codes for the max-heap priority queue
// used by hpq_ram and max_heap_priority_queue; no dependencies
package hpq_pkg;

  localparam int DATA_W      = 32;
  localparam int COUNT_OUT_W = 8;

  typedef logic signed [DATA_W-1:0] word_t;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

>>> rtl/hpq_ram.sv
// hpq_ram: heap entry storage, one write port and two registered read ports,
// plus a shadow register of the root entry (address zero)
// depends on hpq_pkg
module hpq_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  hpq_pkg::word_t wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output hpq_pkg::word_t rdata_a,
  output hpq_pkg::word_t rdata_b,
  output hpq_pkg::word_t root
);

  hpq_pkg::word_t mem [DEPTH];
  hpq_pkg::word_t rdata_a_r;
  hpq_pkg::word_t rdata_b_r;
  hpq_pkg::word_t root_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  // root kept in a flop so max is available without a read cycle
  always_ff @(posedge clk) begin
    if (we && (waddr == '0)) begin
      root_r <= wdata;
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;
  assign root    = root_r;

endmodule

>>> rtl/max_heap_priority_queue.sv
// max_heap_priority_queue: binary max-heap of signed 32-bit values with
// insert, delete-max and max/min query; entries held in hpq_ram
// depends on hpq_pkg and hpq_ram
//
//  channel | ports                                       | handshake
//  --------+---------------------------------------------+------------------------------
//  input   | in_opcode, in_value                         | start high, busy low at edge
//  result  | out_status, out_removed_value, out_max_value,| out_valid high one cycle,
//          | out_min_value, out_entry_count              | always taken
//
// insert: S_INS_RD/S_INS_CMP climb a level per pass, to the root or below a parent not smaller
// delete: S_DEL_LAST takes the last entry; if any remain, S_DEL_RD/S_DEL_CMP sift it down per level
// query: S_QRY scans the entries, one ram read per cycle; errors and the unused opcode go to S_FIN
// rst_n is synchronous; the heap starts empty, no clearing pass
// the result side cannot stall; busy stays high until the result cycle
module max_heap_priority_queue #(
  parameter int CAPACITY = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_opcode,
  input  logic signed [hpq_pkg::DATA_W-1:0]   in_value,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic signed [hpq_pkg::DATA_W-1:0]   out_removed_value,
  output logic signed [hpq_pkg::DATA_W-1:0]   out_max_value,
  output logic signed [hpq_pkg::DATA_W-1:0]   out_min_value,
  output logic [hpq_pkg::COUNT_OUT_W-1:0]     out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;
  localparam logic [2:0] S_INS_CMP  = 3'd2;
  localparam logic [2:0] S_DEL_LAST = 3'd3;
  localparam logic [2:0] S_DEL_RD   = 3'd4;
  localparam logic [2:0] S_DEL_CMP  = 3'd5;
  localparam logic [2:0] S_QRY      = 3'd6;
  localparam logic [2:0] S_FIN      = 3'd7;

  logic [2:0]      state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            pend_r, pend_nxt;
  hpq_pkg::word_t  cur_r, cur_nxt;
  hpq_pkg::word_t  min_r, min_nxt;
  hpq_pkg::word_t  removed_r, removed_nxt;
  logic [1:0]      status_r, status_nxt;

  logic            out_valid_r;
  logic [1:0]      out_status_r;
  hpq_pkg::word_t  out_removed_r;
  hpq_pkg::word_t  out_max_r;
  hpq_pkg::word_t  out_min_r;
  logic [hpq_pkg::COUNT_OUT_W-1:0] out_count_r;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  hpq_pkg::word_t  ram_wdata;
  logic [AW-1:0]   ram_raddr_a;
  logic [AW-1:0]   ram_raddr_b;
  hpq_pkg::word_t  ram_rdata_a;
  hpq_pkg::word_t  ram_rdata_b;
  hpq_pkg::word_t  ram_root;

  logic            accept;
  logic [CW-1:0]   parent_pos;
  logic [CW:0]     left_pos;
  logic [CW:0]     right_pos;
  logic            has_left;
  logic            has_right;
  logic            go_left;
  logic            go_right;
  hpq_pkg::word_t  left_best;

  hpq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b),
    .root    (ram_root)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign parent_pos = pos_r >> 1;
  assign left_pos   = {pos_r, 1'b0};
  assign right_pos  = left_pos + 1'b1;
  assign has_left   = (left_pos <= {1'b0, count_r});
  assign has_right  = (right_pos <= {1'b0, count_r});

  // larger child, left wins a tie
  assign go_left   = (ram_rdata_a > cur_r);
  assign left_best = go_left ? ram_rdata_a : cur_r;
  assign go_right  = has_right && (ram_rdata_b > left_best);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    idx_nxt     = idx_r;
    pend_nxt    = pend_r;
    cur_nxt     = cur_r;
    min_nxt     = min_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    ram_we      = 1'b0;
    ram_waddr   = AW'(pos_r - 1'b1);
    ram_wdata   = cur_r;
    ram_raddr_a = '0;
    ram_raddr_b = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt  = hpq_pkg::ST_OK;
          removed_nxt = '0;
          min_nxt     = '0;
          state_nxt   = S_FIN;
          case (in_opcode)
            hpq_pkg::OP_INSERT: begin
              if (count_r >= CW'(CAPACITY)) begin
                status_nxt = hpq_pkg::ST_FULL;
              end else begin
                count_nxt = CW'(count_r + 1'b1);
                pos_nxt   = CW'(count_r + 1'b1);
                cur_nxt   = in_value;
                state_nxt = S_INS_RD;
              end
            end
            hpq_pkg::OP_DELETE: begin
              if (count_r == '0) begin
                status_nxt = hpq_pkg::ST_EMPTY;
              end else begin
                removed_nxt = ram_root;
                ram_raddr_a = AW'(count_r - 1'b1);
                count_nxt   = CW'(count_r - 1'b1);
                state_nxt   = S_DEL_LAST;
              end
            end
            hpq_pkg::OP_QUERY: begin
              if (count_r == '0) begin
                status_nxt = hpq_pkg::ST_EMPTY;
              end else begin
                min_nxt   = ram_root;
                idx_nxt   = CW'(1);
                pend_nxt  = 1'b0;
                state_nxt = S_QRY;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_INS_RD: begin
        if (pos_r == CW'(1)) begin
          ram_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          ram_raddr_a = AW'(parent_pos - 1'b1);
          state_nxt   = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        ram_we = 1'b1;
        if (cur_r > ram_rdata_a) begin
          // parent moves down into the hole
          ram_wdata = ram_rdata_a;
          pos_nxt   = parent_pos;
          state_nxt = S_INS_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_DEL_LAST: begin
        cur_nxt   = ram_rdata_a;
        pos_nxt   = CW'(1);
        state_nxt = (count_r == '0) ? S_FIN : S_DEL_RD;
      end

      S_DEL_RD: begin
        if (!has_left) begin
          ram_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          ram_raddr_a = AW'(left_pos - 1'b1);
          ram_raddr_b = AW'(left_pos);
          state_nxt   = S_DEL_CMP;
        end
      end

      S_DEL_CMP: begin
        ram_we = 1'b1;
        if (go_right) begin
          ram_wdata = ram_rdata_b;
          pos_nxt   = CW'(right_pos);
          state_nxt = S_DEL_RD;
        end else if (go_left) begin
          ram_wdata = ram_rdata_a;
          pos_nxt   = CW'(left_pos);
          state_nxt = S_DEL_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_QRY: begin
        if (pend_r && (ram_rdata_a < min_r)) begin
          min_nxt = ram_rdata_a;
        end
        if (idx_r < count_r) begin
          ram_raddr_a = AW'(idx_r);
          idx_nxt     = CW'(idx_r + 1'b1);
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= (state_r == S_FIN);
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    idx_r     <= idx_nxt;
    cur_r     <= cur_nxt;
    min_r     <= min_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
    if (state_r == S_FIN) begin
      out_status_r  <= status_r;
      out_removed_r <= removed_r;
      out_max_r     <= (count_r != '0) ? ram_root : '0;
      out_min_r     <= min_r;
      out_count_r   <= hpq_pkg::COUNT_OUT_W'(count_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_max_value     = out_max_r;
  assign out_min_value     = out_min_r;
  assign out_entry_count   = out_count_r;

`ifndef ASSERT_OFF
  a_valid_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_FIN))
    else $error("result strobe without a finishing cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ({1'b0, ram_waddr} < {1'b0, count_r}))
    else $error("heap write outside stored entries");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && (status_r == hpq_pkg::ST_FULL) |-> count_r == CW'(CAPACITY))
    else $error("full status with room left");
`endif

endmodule

>>> verif/tb_max_heap_priority_queue.sv
// tb_max_heap_priority_queue: self-checking bench for the max-heap priority queue,
// a queue-fed command driver, a strobe monitor and a heap predictor kept in step
// depends on hpq_pkg and max_heap_priority_queue (with hpq_ram)
module tb_max_heap_priority_queue;
  import hpq_pkg::*;

  localparam int HEAP_DEPTH     = 128;
  localparam int RANDOM_ITEMS   = 800;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 200;

  // opcode 3 is unused by the block and acts as a no-op
  localparam logic [1:0] OP_NOP = 2'd3;

  typedef struct {
    logic [1:0] opcode;
    word_t      value;
    int         idle_pct;
  } heap_cmd_t;

  typedef struct {
    logic [1:0] status;
    word_t      removed;
    word_t      max_v;
    word_t      min_v;
    logic [7:0] count;
  } heap_reply_t;

  typedef enum {GROW, SHRINK, CHURN} traffic_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic [1:0]                        in_opcode = OP_INSERT;
  logic signed [DATA_W-1:0]          in_value = '0;
  logic                              out_valid;
  logic [1:0]                        out_status;
  logic signed [DATA_W-1:0]          out_removed_value;
  logic signed [DATA_W-1:0]          out_max_value;
  logic signed [DATA_W-1:0]          out_min_value;
  logic [COUNT_OUT_W-1:0]            out_entry_count;

  heap_cmd_t   pending_cmds[$];
  heap_reply_t awaited_replies[$];

  // predictor image of the heap, 1-based like the block
  word_t heap_image[1:HEAP_DEPTH];
  int    image_fill = 0;
  int    peak_fill = 0;

  int gen_fill = 0;
  int failures = 0;
  int idle_cycles = 0;
  int n_insert = 0, n_delete = 0, n_query = 0, n_nop = 0;
  int full_hits = 0, empty_hits = 0;

  max_heap_priority_queue #(
    .CAPACITY(HEAP_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_max_value    (out_max_value),
    .out_min_value    (out_min_value),
    .out_entry_count  (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic note_failure(input string msg);
    $display("mismatch: %s", msg);
    failures++;
  endtask

  function automatic heap_reply_t apply_heap_op(input logic [1:0] op, input word_t val);
    heap_reply_t r;
    int          pos;
    int          big;
    bit          done;
    word_t       tmp;
    r.status  = ST_OK;
    r.removed = '0;
    r.min_v   = '0;
    case (op)
      OP_INSERT: begin
        n_insert++;
        if (image_fill >= HEAP_DEPTH) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          image_fill++;
          heap_image[image_fill] = val;
          pos = image_fill;
          // child climbs only while strictly greater than its parent
          while (pos > 1 && heap_image[pos] > heap_image[pos/2]) begin
            tmp = heap_image[pos];
            heap_image[pos] = heap_image[pos/2];
            heap_image[pos/2] = tmp;
            pos = pos / 2;
          end
          if (image_fill > peak_fill) peak_fill = image_fill;
        end
      end
      OP_DELETE: begin
        n_delete++;
        if (image_fill == 0) begin
          r.status = ST_EMPTY;
          empty_hits++;
        end else begin
          r.removed = heap_image[1];
          heap_image[1] = heap_image[image_fill];
          image_fill--;
          pos = 1;
          done = 1'b0;
          // larger child wins, left child on a tie
          while (!done) begin
            big = pos;
            if (2*pos <= image_fill && heap_image[2*pos] > heap_image[big]) big = 2*pos;
            if (2*pos+1 <= image_fill && heap_image[2*pos+1] > heap_image[big]) big = 2*pos+1;
            if (big == pos) begin
              done = 1'b1;
            end else begin
              tmp = heap_image[big];
              heap_image[big] = heap_image[pos];
              heap_image[pos] = tmp;
              pos = big;
            end
          end
        end
      end
      OP_QUERY: begin
        n_query++;
        if (image_fill == 0) begin
          r.status = ST_EMPTY;
          empty_hits++;
        end else begin
          r.min_v = heap_image[1];
          for (int i = 2; i <= image_fill; i++)
            if (heap_image[i] < r.min_v) r.min_v = heap_image[i];
        end
      end
      default: n_nop++;
    endcase
    r.max_v = (image_fill > 0) ? heap_image[1] : '0;
    r.count = image_fill[7:0];
    return r;
  endfunction

  task automatic push_cmd(input logic [1:0] op, input word_t val, input int idle);
    heap_cmd_t c;
    c.opcode   = op;
    c.value    = val;
    c.idle_pct = idle;
    pending_cmds.push_back(c);
    if (op == OP_INSERT && gen_fill < HEAP_DEPTH) gen_fill++;
    if (op == OP_DELETE && gen_fill > 0) gen_fill--;
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom_range(0, 16)) - 8;
      1: begin
        case ($urandom_range(0, 3))
          0: return word_t'(32'h7fff_ffff);
          1: return word_t'(32'h8000_0000);
          2: return '0;
          default: return '1;
        endcase
      end
      // narrow pool so equal keys meet during sifting
      2: return word_t'($urandom_range(0, 3)) * 1000;
      default: return word_t'($urandom);
    endcase
  endfunction

  // driver: one transaction at a time, start held until the block takes it
  always @(posedge clk) begin : drive
    bit fire;
    fire = start && !busy;
    if (!rst_n) begin
      start     <= 1'b0;
      in_opcode <= OP_INSERT;
      in_value  <= '0;
    end else begin
      if (fire) begin
        awaited_replies.push_back(apply_heap_op(pending_cmds[0].opcode, pending_cmds[0].value));
        void'(pending_cmds.pop_front());
      end
      if (!start || fire) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= pending_cmds[0].idle_pct) begin
          start     <= 1'b1;
          in_opcode <= pending_cmds[0].opcode;
          in_value  <= pending_cmds[0].value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result is matched against the oldest prediction
  always @(posedge clk) begin : watch_results
    heap_reply_t want;
    if (rst_n && out_valid) begin
      if (awaited_replies.size() == 0) begin
        note_failure($sformatf("result with nothing outstanding, status %0d", out_status));
      end else begin
        want = awaited_replies.pop_front();
        if (out_status !== want.status)
          note_failure($sformatf("status got %0d want %0d", out_status, want.status));
        if (out_removed_value !== want.removed)
          note_failure($sformatf("removed_value got %0d want %0d",
                                 out_removed_value, want.removed));
        if (out_max_value !== want.max_v)
          note_failure($sformatf("max_value got %0d want %0d", out_max_value, want.max_v));
        if (out_min_value !== want.min_v)
          note_failure($sformatf("min_value got %0d want %0d", out_min_value, want.min_v));
        if (out_entry_count !== want.count)
          note_failure($sformatf("entry_count got %0d want %0d", out_entry_count, want.count));
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d commands and %0d results outstanding",
                 pending_cmds.size(), awaited_replies.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    traffic_t mode;
    int       r;
    int       idle;
    int       phase_idle[4];
    logic [1:0] op;
    phase_idle = '{0, 52, 0, 11};

    // directed: empty heap corners, extremes, equal keys, unused opcode
    push_cmd(OP_QUERY,  word_t'($urandom), 0);
    push_cmd(OP_DELETE, word_t'($urandom), 0);
    push_cmd(OP_NOP,    '1, 0);
    push_cmd(OP_INSERT, '0, 0);
    push_cmd(OP_INSERT, word_t'(32'h7fff_ffff), 0);
    push_cmd(OP_INSERT, word_t'(32'h8000_0000), 0);
    push_cmd(OP_INSERT, '1, 0);
    push_cmd(OP_INSERT, word_t'(1), 0);
    push_cmd(OP_INSERT, word_t'(5), 0);
    push_cmd(OP_INSERT, word_t'(5), 0);
    push_cmd(OP_INSERT, word_t'(5), 0);
    push_cmd(OP_QUERY,  '0, 0);
    push_cmd(OP_NOP,    word_t'(32'h5555_5555), 0);
    push_cmd(OP_DELETE, word_t'(32'haaaa_aaaa), 0);
    push_cmd(OP_DELETE, '0, 0);
    push_cmd(OP_QUERY,  '1, 0);
    push_cmd(OP_INSERT, word_t'(32'h8000_0000), 0);
    push_cmd(OP_INSERT, word_t'(32'h8000_0000), 0);
    push_cmd(OP_DELETE, '0, 0);
    push_cmd(OP_QUERY,  '0, 0);

    // random: grow to full, shrink to empty, churn in between
    mode = GROW;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle = phase_idle[i * 4 / RANDOM_ITEMS];
      case (mode)
        GROW:   if (gen_fill == HEAP_DEPTH && $urandom_range(0, 5) == 0) mode = SHRINK;
        SHRINK: if (gen_fill == 0 && $urandom_range(0, 3) == 0) mode = CHURN;
        default: if ($urandom_range(0, 39) == 0) mode = GROW;
      endcase
      r = $urandom_range(0, 99);
      case (mode)
        GROW:   op = (r < 75) ? OP_INSERT : (r < 85) ? OP_DELETE : (r < 97) ? OP_QUERY : OP_NOP;
        SHRINK: op = (r < 75) ? OP_DELETE : (r < 85) ? OP_INSERT : (r < 97) ? OP_QUERY : OP_NOP;
        default: op = (r < 40) ? OP_INSERT : (r < 75) ? OP_DELETE : (r < 97) ? OP_QUERY : OP_NOP;
      endcase
      push_cmd(op, (op == OP_INSERT) ? pick_value() : word_t'($urandom), idle);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d inserts, %0d deletes, %0d queries, %0d unused-opcode commands",
             n_insert, n_delete, n_query, n_nop);
    $display("inserts into a full heap %0d, empty-heap deletes and queries %0d, peak fill %0d",
             full_hits, empty_hits, peak_fill);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
